/* design/sol_pkg.sv */
// Shared types and codes for the count-ordered self-organizing list.
// Used by the comparator and the top level; depends on nothing.
package sol_pkg;

  localparam int unsigned KEY_W = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_JSCAN,
    ST_SHIFT,
    ST_PUT,
    ST_RSHIFT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

/* design/frequency_count_self_organizing_list.sv */
// Top level of the count-ordered self-organizing list: sequencer and datapath.
// Depends on sol_pkg, sol_ram and sol_cmp.
//
// The block keeps up to CAPACITY keys with access counts in one RAM and takes
// one request at a time. A search or remove first scans from the head at one
// entry per cycle through the single RAM read port and the shared comparator.
// A search hit at position p then rescans positions 0 to p-1 for the
// reinsertion point j, shifts p-j entries down and writes the moved entry.
// A remove hit at position p shifts the rest up.
// A finished result waits in an output register while the next request is taken.
module frequency_count_self_organizing_list import sol_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] key_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               hit_o
);

  localparam int unsigned IDX_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned ENTRY_W = KEY_W + COUNT_BITS;

  state_e state_q, state_d;

  logic [CNT_W-1:0]      total_q, total_d;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [1:0]            act_q, act_d;
  logic                  dvld_q, dvld_d;
  logic [IDX_W-1:0]      didx_q, didx_d;
  logic [IDX_W-1:0]      pos_q, pos_d;
  logic [IDX_W-1:0]      jpos_q, jpos_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [1:0]            res_status_q, res_status_d;
  logic                  res_hit_q, res_hit_d;
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_status_q, out_status_d;
  logic                  out_hit_q, out_hit_d;

  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
  logic [KEY_W-1:0]      cmp_a, cmp_b;
  cmp_res_t              cmp_res;

  logic                  accept;
  logic                  room;
  logic [KEY_W-1:0]      rd_key;
  logic [COUNT_BITS-1:0] rd_cnt, rd_cnt_inc;
  logic                  scan_match, scan_last;
  logic                  j_found, j_last;
  logic                  out_free;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign room       = (total_q < CNT_W'(CAPACITY));
  assign rd_key     = ram_rdata[ENTRY_W-1:COUNT_BITS];
  assign rd_cnt     = ram_rdata[COUNT_BITS-1:0];
  assign rd_cnt_inc = (&rd_cnt) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
  assign scan_match = dvld_q && cmp_res.eq;
  assign scan_last  = dvld_q && (didx_q == IDX_W'(total_q - CNT_W'(1)));
  assign j_found    = dvld_q && !cmp_res.gt;
  assign j_last     = dvld_q && (didx_q == pos_q - IDX_W'(1));
  assign out_free   = !out_valid_q || out_ready_i;

  sol_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sol_cmp #(
    .WIDTH (KEY_W)
  ) u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_SEARCH, ACT_REMOVE: begin
              state_d = (total_q == '0) ? ST_FINISH : ST_SCAN;
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_match) begin
          if (act_q == ACT_REMOVE) begin
            state_d = ST_RSHIFT;
          end else if (didx_q == '0) begin
            state_d = ST_PUT;
          end else begin
            state_d = ST_JSCAN;
          end
        end else if (scan_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_JSCAN: begin
        if (j_found) begin
          state_d = ST_SHIFT;
        end else if (j_last) begin
          state_d = ST_PUT;
        end
      end
      ST_SHIFT: begin
        if (ptr_q == CNT_W'(jpos_q)) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT:    state_d = ST_FINISH;
      ST_RSHIFT: begin
        if (ptr_q >= total_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    cmp_a     = rd_key;
    cmp_b     = key_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (action_i == ACT_INSERT) && room) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(total_q);
          ram_wdata = {key_i, {COUNT_BITS{1'b0}}};
        end
      end
      ST_SCAN: begin
        ram_re    = (ptr_q < total_q);
        ram_raddr = IDX_W'(ptr_q);
      end
      ST_JSCAN: begin
        ram_re    = (ptr_q < CNT_W'(pos_q));
        ram_raddr = IDX_W'(ptr_q);
        cmp_a     = KEY_W'(rd_cnt);
        cmp_b     = KEY_W'(cnt_q);
      end
      ST_SHIFT: begin
        ram_re    = (ptr_q > CNT_W'(jpos_q));
        ram_raddr = IDX_W'(ptr_q - CNT_W'(1));
        ram_we    = dvld_q;
        ram_waddr = didx_q + IDX_W'(1);
        ram_wdata = ram_rdata;
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = jpos_q;
        ram_wdata = {key_q, cnt_q};
      end
      ST_RSHIFT: begin
        ram_re    = (ptr_q < total_q);
        ram_raddr = IDX_W'(ptr_q);
        ram_we    = dvld_q;
        ram_waddr = didx_q - IDX_W'(1);
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    total_d      = total_q;
    ptr_d        = ptr_q;
    key_d        = key_q;
    act_d        = act_q;
    pos_d        = pos_q;
    jpos_d       = jpos_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_hit_d    = res_hit_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_hit_d    = out_hit_q;
    dvld_d       = ram_re && (state_d == state_q);
    didx_d       = ram_raddr;
    if (ram_re) begin
      ptr_d = (state_q == ST_SHIFT) ? ptr_q - CNT_W'(1) : ptr_q + CNT_W'(1);
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d        = key_i;
          act_d        = action_i;
          ptr_d        = '0;
          res_status_d = STAT_OK;
          res_hit_d    = 1'b0;
          case (action_i)
            ACT_INSERT: begin
              if (room) begin
                total_d = total_q + CNT_W'(1);
              end else begin
                res_status_d = STAT_FULL;
              end
            end
            ACT_SEARCH, ACT_REMOVE: begin
              if (total_q == '0) begin
                res_status_d = STAT_MISS;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_match) begin
          pos_d  = didx_q;
          cnt_d  = rd_cnt_inc;
          jpos_d = '0;
          ptr_d  = (act_q == ACT_REMOVE) ? CNT_W'(didx_q) + CNT_W'(1) : '0;
        end else if (scan_last) begin
          res_status_d = STAT_MISS;
        end
      end
      ST_JSCAN: begin
        if (j_found) begin
          jpos_d = didx_q;
          ptr_d  = CNT_W'(pos_q);
        end else if (j_last) begin
          jpos_d = pos_q;
        end
      end
      ST_PUT: begin
        res_status_d = STAT_OK;
        res_hit_d    = 1'b1;
      end
      ST_RSHIFT: begin
        if (ptr_q >= total_q) begin
          total_d      = total_q - CNT_W'(1);
          res_status_d = STAT_OK;
          res_hit_d    = 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_hit_d    = res_hit_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      ptr_q       <= '0;
      dvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      ptr_q       <= ptr_d;
      dvld_q      <= dvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    act_q        <= act_d;
    didx_q       <= didx_d;
    pos_q        <= pos_d;
    jpos_q       <= jpos_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_hit_q    <= res_hit_d;
    out_status_q <= out_status_d;
    out_hit_q    <= out_hit_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign hit_o       = out_hit_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(CAPACITY))
    else $error("Entry total exceeds the table capacity.");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (jpos_q < pos_q) && (ptr_q >= CNT_W'(jpos_q)))
    else $error("Reinsertion shift runs outside its window.");

  a_remove_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RSHIFT) |-> (total_q != '0) && (CNT_W'(pos_q) < total_q))
    else $error("Remove shift started on an entry beyond the total.");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && out_valid_q && !out_ready_i |=> (state_q == ST_FINISH))
    else $error("A result left the sequencer while the output register was full.");

endmodule

/* design/sol_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Stands alone; no package needed.
module sol_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/sol_cmp.sv */
// Shared unsigned comparator used for key matching and count ordering.
// Depends on sol_pkg for the result struct.
module sol_cmp import sol_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output cmp_res_t         res_o
);

  always_comb begin
    res_o.eq = (a_i == b_i);
    res_o.gt = (a_i > b_i);
  end

endmodule
